/* hw/rtl/mad_pkg.sv */
// shared types and constants for the median absolute deviation unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mad_pkg;
  localparam int unsigned MaxSamples = 256;
  localparam int unsigned SampleBits = 32;
  localparam int unsigned CountBits  = 9;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEL_RD,
    ST_SEL_CMP,
    ST_DEV,
    ST_DEV_WR,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

/* hw/rtl/mad_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mad_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hw/rtl/median_absolute_deviation_unit.sv */
// median and median absolute deviation of a loaded sample set
// depends on mad_pkg and mad_ram
`timescale 1ns / 1ps
`default_nettype none
// usage:
// - s_axis carries samples, one word per cycle while loading; tlast closes
//   the set and starts computation
// - samples past MaxSamples are dropped and flagged in the result
// - the median is found by rank counting: for each candidate i the whole
//   store is read once through one shared comparator, counting entries that
//   sort strictly below it and equal to it; the candidate whose rank window
//   covers n/2 is the answer
// - the same selection is then run on the absolute deviations, which are
//   produced in one pass by one shared subtractor
// - after the tlast word each candidate is fetched in ST_SEL_RD and scanned in
//   ST_SEL_CMP, and each deviation is read in ST_DEV and written in ST_DEV_WR;
//   ready stays low throughout
// - one result word on m_axis; the block holds it until m_axis_tready,
//   then returns to loading a new set
// - reset clears count, overflow flag and state; stores need no clearing
//   since only entries written in the current set are read
module median_absolute_deviation_unit #(
  parameter int unsigned MAX_SAMPLES = mad_pkg::MaxSamples,
  parameter int unsigned SAMPLE_BITS = mad_pkg::SampleBits
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                     s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // median_value, abs_deviation, sample_count(9), overflowed(1), zero fill
  output logic [((2*SAMPLE_BITS+mad_pkg::CountBits+1+7)/8)*8-1:0] m_axis_tdata
);
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = mad_pkg::CountBits;
  localparam int unsigned OW = ((2*SAMPLE_BITS+CW+1+7)/8)*8;
  localparam logic [SAMPLE_BITS-1:0] SignBit = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  mad_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          pass_q, pass_d;      // 0 sample selection, 1 deviation selection
  logic [AW-1:0] cand_q, cand_d;      // candidate index
  logic [CW-1:0] scan_q, scan_d;      // scan index
  logic [CW-1:0] lt_q, lt_d, eq_q, eq_d;
  logic [SAMPLE_BITS-1:0] key_q, key_d, med_q, med_d, dev_q, dev_d;
  logic          rd_pend_q, rd_pend_d;

  logic                   s_we, d_we;
  logic [AW-1:0]          s_wa, d_wa, rd_a;
  logic [SAMPLE_BITS-1:0] s_wd, d_wd, s_rd, d_rd, rd;
  logic [CW-1:0]          mid;

  mad_ram #(.Width(SAMPLE_BITS), .Depth(MAX_SAMPLES)) u_samples (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(rd_a), .rdata_o(s_rd));
  mad_ram #(.Width(SAMPLE_BITS), .Depth(MAX_SAMPLES)) u_devs (
    .clk_i, .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd), .raddr_i(rd_a), .rdata_o(d_rd));

  assign mid = cnt_q >> 1;
  assign rd  = pass_q ? d_rd : s_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mad_pkg::ST_LOAD;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      pass_q <= 1'b0;
      cand_q <= '0;
      scan_q <= '0;
      lt_q <= '0;
      eq_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      pass_q <= pass_d;
      cand_q <= cand_d;
      scan_q <= scan_d;
      lt_q <= lt_d;
      eq_q <= eq_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    med_q <= med_d;
    dev_q <= dev_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; ovf_d = ovf_q; pass_d = pass_q;
    cand_d = cand_q; scan_d = scan_q; lt_d = lt_q; eq_d = eq_q;
    key_d = key_q; med_d = med_q; dev_d = dev_q; rd_pend_d = 1'b0;
    s_we = 1'b0; s_wa = cnt_q[AW-1:0];
    s_wd = s_axis_tdata[SAMPLE_BITS-1:0] ^ SignBit;
    d_we = 1'b0; d_wa = scan_q[AW-1:0]; d_wd = '0;
    rd_a = scan_q[AW-1:0];
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      mad_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (cnt_q < CW'(MAX_SAMPLES)) begin
            s_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = mad_pkg::ST_SEL_RD;
            pass_d = 1'b0;
            cand_d = '0;
          end
        end
      end
      // fetch candidate value
      mad_pkg::ST_SEL_RD: begin
        rd_a = cand_q;
        if (rd_pend_q) begin
          key_d = rd;
          scan_d = '0; lt_d = '0; eq_d = '0;
          state_d = mad_pkg::ST_SEL_CMP;
        end else begin
          rd_pend_d = 1'b1;
        end
      end
      // count entries below and equal to the candidate, one per cycle
      mad_pkg::ST_SEL_CMP: begin
        rd_a = scan_q[AW-1:0];
        if (scan_q < cnt_q) begin
          scan_d = scan_q + 1'b1;
        end
        rd_pend_d = (scan_q < cnt_q);
        if (rd_pend_q) begin
          if (rd < key_q) lt_d = lt_q + 1'b1;
          else if (rd == key_q) eq_d = eq_q + 1'b1;
        end
        if (!rd_pend_q && scan_q == cnt_q) begin
          if (lt_q <= mid && mid < lt_q + eq_q) begin
            if (!pass_q) begin
              med_d = key_q;
              scan_d = '0;
              state_d = mad_pkg::ST_DEV;
            end else begin
              dev_d = key_q;
              state_d = mad_pkg::ST_OUT;
            end
          end else begin
            cand_d = cand_q + 1'b1;
            state_d = mad_pkg::ST_SEL_RD;
          end
        end
      end
      // issue read of sample scan_q, or start the deviation selection once all are written
      mad_pkg::ST_DEV: begin
        rd_a = scan_q[AW-1:0];
        if (scan_q == cnt_q) begin
          pass_d = 1'b1;
          cand_d = '0;
          state_d = mad_pkg::ST_SEL_RD;
        end else begin
          state_d = mad_pkg::ST_DEV_WR;
        end
      end
      // one shared subtractor writes |x - median|
      mad_pkg::ST_DEV_WR: begin
        d_we = 1'b1;
        d_wd = (s_rd >= med_q) ? (s_rd - med_q) : (med_q - s_rd);
        scan_d = scan_q + 1'b1;
        state_d = mad_pkg::ST_DEV;
      end
      mad_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          cnt_d = '0;
          ovf_d = 1'b0;
          pass_d = 1'b0;
          state_d = mad_pkg::ST_LOAD;
        end
      end
      default: state_d = mad_pkg::ST_LOAD;
    endcase
  end

  assign m_axis_tdata = OW'({ovf_q, cnt_q, dev_q, med_q ^ SignBit});
endmodule
`default_nettype wire

/* bench/median_absolute_deviation_unit_test.sv */
// self-checking bench for the median absolute deviation unit
// depends on mad_pkg and median_absolute_deviation_unit
`timescale 1ns / 1ps
module median_absolute_deviation_unit_test;
  localparam int unsigned SampleBits = mad_pkg::SampleBits;
  localparam int unsigned CountBits  = mad_pkg::CountBits;
  localparam int unsigned MaxSamples = mad_pkg::MaxSamples;
  localparam int unsigned DataW   = ((SampleBits + 7) / 8) * 8;
  localparam int unsigned ResW    = ((2 * SampleBits + CountBits + 1 + 7) / 8) * 8;
  localparam int unsigned MaxCycles = 4_000_000;  // cycle limit for the whole run

  typedef struct {
    logic signed [SampleBits-1:0] sample;
    bit                           last;
    bit                           drain;   // wait until no result is pending
  } word_t;

  typedef struct {
    logic signed [SampleBits-1:0] median;
    logic [SampleBits-1:0]        mad;
    logic [CountBits-1:0]         count;
    bit                           ovf;
  } stat_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [DataW-1:0] s_axis_tdata;  // sample
  logic m_axis_tvalid, m_axis_tready;
  // median_value, abs_deviation, sample_count, overflowed, zero fill
  logic [ResW-1:0] m_axis_tdata;

  median_absolute_deviation_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  word_t pending_words[$];
  stat_t expected_stats[$];
  logic signed [SampleBits-1:0] open_set[$];  // kept samples of the set being loaded
  bit open_ovf;
  int unsigned errors, words_sent, sets_done, cycles, sets_overflowed;
  bit hold_off_req;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch in set %0d: %s got %h want %h", sets_done, what, got, want);
  endtask

  // rank n/2 of the kept samples, then rank n/2 of their distances from it
  function automatic stat_t median_and_mad(input logic signed [SampleBits-1:0] xs[$],
                                           input bit ovf);
    logic signed [SampleBits-1:0] s[$];
    logic [SampleBits-1:0] d[$];
    logic signed [SampleBits-1:0] ks;
    logic [SampleBits-1:0] kd;
    logic signed [SampleBits:0] diff;
    stat_t r;
    int j;
    s = xs;
    for (int i = 1; i < s.size(); i++) begin
      ks = s[i];
      j = i;
      while (j > 0 && s[j-1] > ks) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = ks;
    end
    r.median = s[s.size() / 2];
    foreach (s[i]) begin
      diff = {s[i][SampleBits-1], s[i]} - {r.median[SampleBits-1], r.median};
      d.push_back(diff < 0 ? SampleBits'(-diff) : SampleBits'(diff));
    end
    for (int i = 1; i < d.size(); i++) begin
      kd = d[i];
      j = i;
      while (j > 0 && d[j-1] > kd) begin
        d[j] = d[j-1];
        j--;
      end
      d[j] = kd;
    end
    r.mad = d[d.size() / 2];
    r.count = CountBits'(s.size());
    r.ovf = ovf;
    return r;
  endfunction

  // driver: one word per draw, a random gap after each word, quiet stretches with no gaps
  int unsigned gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    word_t w;
    bit take;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_left      <= 0;
    end else begin
      take = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        take = 1'b1;
        words_sent++;
        if (open_set.size() < MaxSamples) open_set.push_back(s_axis_tdata[SampleBits-1:0]);
        else open_ovf = 1'b1;
        if (s_axis_tlast) begin
          expected_stats.push_back(median_and_mad(open_set, open_ovf));
          if (open_ovf) sets_overflowed++;
          open_set.delete();
          open_ovf = 1'b0;
        end
      end
      if (take) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].drain || expected_stats.size() == 0)) begin
          w = pending_words.pop_front();
          s_axis_tdata  <= w.sample;
          s_axis_tlast  <= w.last;
          s_axis_tvalid <= 1'b1;
          gap_left <= ((words_sent / 96) % 3 == 0) ? 0 : $urandom_range(0, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off of the receiver, started once six sets are back
  int unsigned hold_left;
  bit hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      hold_done    <= 1'b0;
      hold_off_req <= 1'b0;
    end else if (!hold_done && sets_done >= 6) begin
      hold_left    <= 400;
      hold_done    <= 1'b1;
      hold_off_req <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left    <= 0;
      hold_off_req <= 1'b0;
    end
  end

  // monitor: random stalls, held off while the long hold-off runs
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    stat_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_stats.size() == 0) begin
          report("unexpected result", m_axis_tdata[63:0], '0);
        end else begin
          e = expected_stats.pop_front();
          if (m_axis_tdata[31:0] !== e.median) report("median", m_axis_tdata[31:0], e.median);
          if (m_axis_tdata[63:32] !== e.mad) report("mad", m_axis_tdata[63:32], e.mad);
          if (m_axis_tdata[72:64] !== e.count) report("count", m_axis_tdata[72:64], e.count);
          if (m_axis_tdata[73] !== e.ovf) report("overflow", m_axis_tdata[73], e.ovf);
        end
        sets_done++;
        stall_left <= ((sets_done / 20) % 3 == 1) ? 0 : $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !hold_off_req;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_word(input logic signed [SampleBits-1:0] v, input bit last,
                           input bit drain = 1'b0);
    word_t w;
    w.sample = v;
    w.last = last;
    w.drain = drain;
    pending_words.push_back(w);
  endtask

  function automatic logic signed [SampleBits-1:0] draw_sample(input int unsigned style);
    case (style)
      0: return $urandom;
      1: return $signed($urandom_range(0, 15)) - 8;   // many ties
      2: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  initial begin
    int unsigned n, style, total_words;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    open_ovf = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single extremes, widest spread, ties, even and odd sizes
    push_word(32'sh8000_0000, 1);
    push_word(32'sh7FFF_FFFF, 1);
    push_word(32'sh8000_0000, 0);
    push_word(32'sh7FFF_FFFF, 1);
    push_word(0, 0);
    push_word(-1, 0);
    push_word(1, 0);
    push_word(32'sh7FFF_FFFF, 0);
    push_word(32'sh8000_0000, 1);
    repeat (3) push_word(5, 0);
    push_word(5, 1);
    push_word(32'sh5555_5555, 0);
    push_word(32'shAAAA_AAAA, 0);
    push_word(-7, 1);

    // sender pause until every result is back
    push_word(42, 1, 1'b1);

    // random sets, mostly small
    while (pending_words.size() < 730) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      style = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) push_word(draw_sample(style), i == n - 1);
    end
    // store exactly full, then overflow including the closing word
    for (int i = 0; i < MaxSamples; i++) push_word(draw_sample(0), i == MaxSamples - 1);
    for (int i = 0; i < MaxSamples + 3; i++)
      push_word(draw_sample(3), i == MaxSamples + 2, i == 0);
    for (int i = 0; i < 6; i++) push_word(draw_sample(1), i == 5);
    total_words = pending_words.size();

    while (words_sent < total_words || expected_stats.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d words in %0d sets, %0d with dropped samples, ties and full-range extremes",
             words_sent, sets_done, sets_overflowed);
    if (errors == 0 && expected_stats.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
